@@ hdl/cst_pkg.sv @@
// shared constants and codes for the connection slot table
// no dependencies; imported by the top level, the checker and the testbench
`default_nettype none

package cst_pkg;

    localparam int SLOTS_DEF = 4;    // default number of connection slots
    localparam int SLOTS_MAX = 16;   // largest slot count the port widths allow

    localparam int ID_W    = 8;      // client id width
    localparam int TIME_W  = 32;     // millisecond time stamp width
    localparam int SLOT_W  = 4;      // slot index port width
    localparam int COUNT_W = 5;      // connected count port width

    localparam logic MODE_CONNECT    = 1'b0;
    localparam logic MODE_DISCONNECT = 1'b1;

endpackage

`default_nettype wire

@@ hdl/cst_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing; used for the slot entry storage
`default_nettype none

module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/connection_slot_table_oldest_evict.sv @@
// connection slot table with oldest-entry eviction: top level, uses cst_pkg and cst_ram
// flow: a connect with a free slot goes straight from idle to the update step, while a connect
//   on a full table or a disconnect first scans the ram (one ram read per slot, plus update)
// handshake: busy drops as the result shows, and start is only taken while the block is idle
// results cannot be stalled: each one is shown for a single cycle on o_strobe
// reset (i_rst_n low, synchronous) frees every slot at once; ram holds no reset
`default_nettype none

module connection_slot_table_oldest_evict
    import cst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_mode,
    input  wire logic [ID_W-1:0]    i_client_id,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    output logic                    o_strobe,
    output logic [SLOT_W-1:0]       o_slot_index,
    output logic                    o_found,
    output logic                    o_evicted,
    output logic [ID_W-1:0]         o_evicted_id,
    output logic [COUNT_W-1:0]      o_connected_count
);

    // index width into the slot arrays, and a counter wide enough to hold SLOTS
    localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int ENTRY_W = ID_W + TIME_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;

    // latched transaction
    logic              r_mode;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_now;
    logic              r_full;      // table was full when the connect arrived

    // occupancy lives in flip-flops so reset frees every slot at once
    logic [SLOTS-1:0]   r_occ;
    logic [COUNT_W-1:0] r_count;

    // scan pipeline: address issue counter and returned-data tag
    logic [CW-1:0] r_issue;
    logic          r_dvld;
    logic [IW-1:0] r_didx;

    // scan results
    logic [TIME_W-1:0] r_best_age;
    logic [IW-1:0]     r_best;
    logic [ID_W-1:0]   r_ev_id;
    logic              r_hit;

    // ram ports
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [ID_W-1:0]   rd_client;
    logic [TIME_W-1:0] rd_stamp;
    logic [TIME_W-1:0] rd_age;

    logic [IW-1:0] first_free;
    logic [IW-1:0] fill_idx;

    // lowest-numbered free slot (only used when the table is not full)
    always_comb begin
        first_free = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                first_free = IW'(i);
            end
        end
    end

    // eviction frees the oldest slot, and that is then the only free one
    assign fill_idx = r_full ? r_best : first_free;

    assign rd_client = ram_rdata[ENTRY_W-1:TIME_W];
    assign rd_stamp  = ram_rdata[TIME_W-1:0];
    assign rd_age    = r_now - rd_stamp;   // wraps modulo 2^32

    assign ram_re    = (r_state == S_SCAN) && (r_issue < CW'(SLOTS));
    assign ram_we    = (r_state == S_FINISH) && (r_mode == MODE_CONNECT);
    assign ram_waddr = fill_idx;
    assign ram_wdata = {r_id, r_now};

    assign busy = (r_state != S_IDLE);

    cst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_issue[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_count  <= '0;
            r_dvld   <= 1'b0;
            r_issue  <= '0;
            r_hit    <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            // the result shows in the cycle after the update step
            o_strobe <= (r_state == S_FINISH);
            r_dvld   <= ram_re;
            r_didx   <= r_issue[IW-1:0];
            if (ram_re) begin
                r_issue <= r_issue + CW'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode     <= i_mode;
                        r_id       <= i_client_id;
                        r_now      <= i_now_ms;
                        r_full     <= (r_count == COUNT_W'(SLOTS));
                        r_issue    <= '0;
                        r_best_age <= '0;
                        r_best     <= '0;
                        r_ev_id    <= '0;
                        r_hit      <= 1'b0;
                        // connect with room left needs no ram read
                        if (i_mode == MODE_CONNECT && r_count != COUNT_W'(SLOTS)) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    if (r_dvld) begin
                        if (r_mode == MODE_CONNECT) begin
                            // ties go to the later slot
                            if (rd_age >= r_best_age) begin
                                r_best_age <= rd_age;
                                r_best     <= r_didx;
                                r_ev_id    <= rd_client;
                            end
                        end else if (!r_hit && r_occ[r_didx] && rd_client == r_id) begin
                            r_hit  <= 1'b1;
                            r_best <= r_didx;
                        end
                        if (r_didx == IW'(SLOTS - 1)) begin
                            r_state <= S_FINISH;
                        end
                    end
                end

                S_FINISH: begin
                    r_state  <= S_IDLE;
                    if (r_mode == MODE_CONNECT) begin
                        r_occ[fill_idx]   <= 1'b1;
                        o_slot_index      <= SLOT_W'(fill_idx);
                        o_found           <= 1'b1;
                        o_evicted         <= r_full;
                        o_evicted_id      <= r_full ? r_ev_id : '0;
                        o_connected_count <= r_full ? r_count : r_count + COUNT_W'(1);
                        if (!r_full) begin
                            r_count <= r_count + COUNT_W'(1);
                        end
                    end else begin
                        o_evicted    <= 1'b0;
                        o_evicted_id <= '0;
                        if (r_hit) begin
                            // freed entry contents stay in the ram and are ignored by scans until refilled
                            r_occ[r_best]     <= 1'b0;
                            r_count           <= r_count - COUNT_W'(1);
                            o_slot_index      <= SLOT_W'(r_best);
                            o_found           <= 1'b1;
                            o_connected_count <= r_count - COUNT_W'(1);
                        end else begin
                            o_slot_index      <= '0;
                            o_found           <= 1'b0;
                            o_connected_count <= r_count;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/cst_checker.sv @@
// port-level checker for the connection slot table, with its bind
// depends on cst_pkg and the top level connection_slot_table_oldest_evict
`default_nettype none

module cst_checker
    import cst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_strobe,
    input wire logic [SLOT_W-1:0]  o_slot_index,
    input wire logic               o_found,
    input wire logic               o_evicted,
    input wire logic [COUNT_W-1:0] o_connected_count
);

    // an accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accepted transaction");

    // a transaction ends exactly when its result shows
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy fell without a result");

    // eviction only happens on a full table and always fills a slot
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_evicted) |-> (o_found && o_connected_count == COUNT_W'(SLOTS)))
        else $error("eviction reported without a full table");

    // a miss reports slot zero and no eviction
    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |-> (o_slot_index == '0 && !o_evicted))
        else $error("miss result with nonzero slot or eviction");

    // count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_connected_count <= COUNT_W'(SLOTS)))
        else $error("connected count above slot count");

endmodule

bind connection_slot_table_oldest_evict cst_checker #(
    .SLOTS (SLOTS)
) u_cst_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_strobe          (o_strobe),
    .o_slot_index      (o_slot_index),
    .o_found           (o_found),
    .o_evicted         (o_evicted),
    .o_connected_count (o_connected_count)
);

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// testbench for connection_slot_table_oldest_evict: directed event table, then random traffic
// depends on cst_pkg and the block's rtl; self-checking against a built-in slot table predictor

module testbench;
    import cst_pkg::*;

    localparam int NSLOTS     = SLOTS_DEF;
    localparam int CLK_PERIOD = 20;
    localparam int NROWS      = 21;
    localparam int ID_POOL    = 6;
    localparam int PHASE_LEN  = 190;

    // one result transaction as seen on the output ports
    typedef struct packed {
        logic [SLOT_W-1:0]  slot_index;
        logic               found;
        logic               evicted;
        logic [ID_W-1:0]    evicted_id;
        logic [COUNT_W-1:0] connected_count;
    } t_slot_result;

    // one row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        logic              typed;
        t_slot_result      result;
    } t_event_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_mode;
    logic [ID_W-1:0]    i_client_id;
    logic [TIME_W-1:0]  i_now_ms;
    logic               o_strobe;
    logic [SLOT_W-1:0]  o_slot_index;
    logic               o_found;
    logic               o_evicted;
    logic [ID_W-1:0]    o_evicted_id;
    logic [COUNT_W-1:0] o_connected_count;

    connection_slot_table_oldest_evict #(
        .SLOTS (NSLOTS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_mode            (i_mode),
        .i_client_id       (i_client_id),
        .i_now_ms          (i_now_ms),
        .o_strobe          (o_strobe),
        .o_slot_index      (o_slot_index),
        .o_found           (o_found),
        .o_evicted         (o_evicted),
        .o_evicted_id      (o_evicted_id),
        .o_connected_count (o_connected_count)
    );

    // predictor's own copy of the slot table
    bit                tbl_used   [NSLOTS];
    logic [ID_W-1:0]   tbl_client [NSLOTS];
    logic [TIME_W-1:0] tbl_stamp  [NSLOTS];

    // results predicted for accepted transactions, oldest first
    t_slot_result pending_results[$];
    int           mismatch_count;

    // directed events: empty-table lookups, field extremes, age wrap, duplicate ids, age ties
    t_event_row directed_rows [NROWS] = '{
        // free slots hold id 0 in the predictor but must never match a disconnect
        '{MODE_DISCONNECT, 8'h00, 32'h0000_0000, 1'b1, '{4'd0, 1'b0, 1'b0, 8'h00, 5'd0}},
        // first connect after reset lands in slot 0
        '{MODE_CONNECT,    8'hFF, 32'hFFFF_FFFF, 1'b1, '{4'd0, 1'b1, 1'b0, 8'h00, 5'd1}},
        '{MODE_CONNECT,    8'h00, 32'h0000_0000, 1'b0, '0},
        // same id twice: a second entry, no id check on connect
        '{MODE_CONNECT,    8'hFF, 32'h8000_0000, 1'b0, '0},
        '{MODE_CONNECT,    8'hA5, 32'h7FFF_FFFF, 1'b0, '0},
        // full table, stamps straddle the wrap point
        '{MODE_CONNECT,    8'h5A, 32'h0000_0010, 1'b0, '0},
        // duplicate id: lowest matching slot goes first
        '{MODE_DISCONNECT, 8'hFF, 32'h0000_0020, 1'b0, '0},
        '{MODE_DISCONNECT, 8'hFF, 32'h0000_0021, 1'b0, '0},
        '{MODE_DISCONNECT, 8'h00, 32'h0000_0022, 1'b0, '0},
        '{MODE_DISCONNECT, 8'h5A, 32'h0000_0023, 1'b0, '0},
        // table empty again, nothing to free
        '{MODE_DISCONNECT, 8'h5A, 32'h0000_0024, 1'b1, '{4'd0, 1'b0, 1'b0, 8'h00, 5'd0}},
        // fill with identical stamps
        '{MODE_CONNECT,    8'h01, 32'd100,       1'b0, '0},
        '{MODE_CONNECT,    8'h02, 32'd100,       1'b0, '0},
        '{MODE_CONNECT,    8'h03, 32'd100,       1'b0, '0},
        '{MODE_CONNECT,    8'h04, 32'd100,       1'b0, '0},
        // unknown id on a full table
        '{MODE_DISCONNECT, 8'h77, 32'd150,       1'b0, '0},
        // four-way age tie: highest index is evicted
        '{MODE_CONNECT,    8'h80, 32'd200,       1'b0, '0},
        // three-way tie among older entries
        '{MODE_CONNECT,    8'h7F, 32'd200,       1'b0, '0},
        // time went backwards: every age wraps to a huge value
        '{MODE_CONNECT,    8'h33, 32'd50,        1'b0, '0},
        '{MODE_DISCONNECT, 8'h01, 32'd60,        1'b0, '0},
        '{MODE_CONNECT,    8'hC3, 32'hFFFF_FFFE, 1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // hard stop in case the handshake hangs
    initial begin
        #5_000_000;
        $display("[connection_slot_table_oldest_evict] ERROR");
        $finish;
    end

    // apply one event to the predictor's table and return the result it causes
    function automatic t_slot_result apply_event(input logic mode, input logic [ID_W-1:0] id,
                                                 input logic [TIME_W-1:0] now);
        t_slot_result      res;
        int                used_n;
        int                oldest;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] best_age;
        bit                done;
        res      = '0;
        used_n   = 0;
        oldest   = 0;
        best_age = '0;
        done     = 1'b0;
        for (int i = 0; i < NSLOTS; i++) used_n += tbl_used[i];
        if (mode == MODE_CONNECT) begin
            // full table: drop the oldest, ties go to the highest index
            if (used_n == NSLOTS) begin
                for (int i = 0; i < NSLOTS; i++) begin
                    age = now - tbl_stamp[i];
                    if (age >= best_age) begin
                        best_age = age;
                        oldest   = i;
                    end
                end
                res.evicted       = 1'b1;
                res.evicted_id    = tbl_client[oldest];
                tbl_used[oldest]   = 1'b0;
                tbl_client[oldest] = '0;
                tbl_stamp[oldest]  = now;
                used_n--;
            end
            for (int i = 0; i < NSLOTS; i++) begin
                if (!done && !tbl_used[i]) begin
                    tbl_used[i]    = 1'b1;
                    tbl_client[i]  = id;
                    tbl_stamp[i]   = now;
                    res.slot_index = SLOT_W'(i);
                    res.found      = 1'b1;
                    done           = 1'b1;
                    used_n++;
                end
            end
        end else begin
            for (int i = 0; i < NSLOTS; i++) begin
                if (!done && tbl_used[i] && tbl_client[i] == id) begin
                    tbl_used[i]    = 1'b0;
                    tbl_client[i]  = '0;
                    tbl_stamp[i]   = now;
                    res.slot_index = SLOT_W'(i);
                    res.found      = 1'b1;
                    done           = 1'b1;
                    used_n--;
                end
            end
        end
        res.connected_count = COUNT_W'(used_n);
        return res;
    endfunction

    // start low, with junk on the payload that the block must ignore; n sets the length of the gap
    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start       <= 1'b0;
            i_mode      <= 1'($urandom);
            i_client_id <= ID_W'($urandom);
            i_now_ms    <= TIME_W'($urandom);
        end
    endtask

    // present one event and hold it until the block takes it
    task automatic send_event(input logic mode, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] now, input bit typed,
                              input t_slot_result typed_result);
        t_slot_result predicted;
        @(negedge i_clk);
        start       <= 1'b1;
        i_mode      <= mode;
        i_client_id <= id;
        i_now_ms    <= now;
        do @(posedge i_clk); while (busy !== 1'b0);
        // transaction accepted at this edge
        predicted = apply_event(mode, id, now);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // lower start and hold off until every expected result is back or the wait limit runs out
    task automatic drain_results(input int max_cycles);
        int waited;
        waited = 0;
        idle_for(1);
        while (pending_results.size() != 0 && waited < max_cycles) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // output side: every strobe must match the oldest expectation, field by field
    always @(posedge i_clk) begin : check_results
        t_slot_result seen;
        t_slot_result want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            seen = '{o_slot_index, o_found, o_evicted, o_evicted_id, o_connected_count};
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: result with nothing expected: slot %0d found %0b ev %0b",
                             $realtime, seen.slot_index, seen.found, seen.evicted,
                             " id %h cnt %0d", seen.evicted_id, seen.connected_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (seen.slot_index !== want.slot_index || seen.found !== want.found ||
                    seen.evicted !== want.evicted || seen.evicted_id !== want.evicted_id ||
                    seen.connected_count !== want.connected_count) begin
                    if (mismatch_count < 10)
                        $display("%0t: mismatch exp slot %0d found %0b ev %0b id %h cnt %0d",
                                 $realtime, want.slot_index, want.found, want.evicted,
                                 want.evicted_id, want.connected_count,
                                 " / got slot %0d found %0b ev %0b id %h cnt %0d",
                                 seen.slot_index, seen.found, seen.evicted,
                                 seen.evicted_id, seen.connected_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int                idle_pct [4];
        logic [ID_W-1:0]   id_pool [ID_POOL];
        logic [TIME_W-1:0] clock_ms;
        logic [ID_W-1:0]   pick_id;
        logic              pick_mode;
        int                roll;

        idle_pct = '{0, 60, 21, 40};
        mismatch_count = 0;
        for (int i = 0; i < NSLOTS; i++) begin
            tbl_used[i]   = 1'b0;
            tbl_client[i] = '0;
            tbl_stamp[i]  = '0;
        end

        // every input known from time zero, with reset held low at the start
        start       = 1'b0;
        i_rst_n     = 1'b0;
        i_mode      = MODE_CONNECT;
        i_client_id = '0;
        i_now_ms    = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_for(2);

        // directed table, with start lowered now and then between rows
        for (int r = 0; r < NROWS; r++) begin
            send_event(directed_rows[r].mode, directed_rows[r].id, directed_rows[r].now,
                       directed_rows[r].typed, directed_rows[r].result);
            if ($urandom_range(0, 3) == 0) idle_for(1);
        end
        drain_results(1000);

        // random traffic: a small id pool so disconnects hit and the table fills up
        clock_ms = $urandom;
        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < ID_POOL; k++) id_pool[k] = ID_W'($urandom);
            for (int n = 0; n < PHASE_LEN; n++) begin
                roll = $urandom_range(0, 99);
                // mostly forward time, some repeats for age ties, some wild jumps
                if (roll < 10)
                    clock_ms = clock_ms;
                else if (roll < 80)
                    clock_ms = clock_ms + $urandom_range(1, 1000);
                else if (roll < 95)
                    clock_ms = clock_ms + $urandom;
                else
                    clock_ms = $urandom;
                pick_id   = ($urandom_range(0, 99) < 85)
                          ? id_pool[$urandom_range(0, ID_POOL - 1)]
                          : ID_W'($urandom);
                pick_mode = ($urandom_range(0, 99) < 55) ? MODE_CONNECT : MODE_DISCONNECT;
                send_event(pick_mode, pick_id, clock_ms, 1'b0, '0);
                if ($urandom_range(0, 99) < idle_pct[ph]) idle_for($urandom_range(1, 6));
            end
            // let the table go quiet between phases
            drain_results(1000);
        end

        drain_results(10000);
        repeat (NSLOTS + 8) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[connection_slot_table_oldest_evict] OK");
        end else begin
            $display("[connection_slot_table_oldest_evict] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/cst_pkg.sv
hdl/cst_ram.sv
hdl/connection_slot_table_oldest_evict.sv
hdl/cst_checker.sv
test/testbench.sv
